// ----- rtl/hdf_pkg.sv -----
`default_nettype none
package hdf_pkg;

  localparam int BLOCK_SIZE_DEF = 8;
  localparam int BLOCK_MIN      = 3;
  localparam int BLOCK_MAX      = 8;

  localparam int CAND_W   = 64;
  localparam int CNT_W    = 4;   // holds a ones count up to BLOCK_MAX
  localparam int SCORE_W  = 17;  // Q.16, up to 1.0
  localparam int SUM_W    = 20;  // BLOCK_MAX scores
  localparam int WEIGHT_W = 12;  // Q4.8
  localparam int LEVEL_W  = SUM_W + WEIGHT_W;
  localparam int TOP_W    = SCORE_W + WEIGHT_W;
  localparam int ACC_W    = LEVEL_W + 1;
  localparam int FIT_W    = 24;  // Q8.16
  localparam int RND_W    = ACC_W - 8;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic REG_LEVEL = 1'b0;
  localparam logic REG_TOP   = 1'b1;

  localparam logic [WEIGHT_W-1:0] LEVEL_RST = 12'd256;
  localparam logic [WEIGHT_W-1:0] TOP_RST   = 12'd512;

  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(128);

  // Deceptive score per ones count, one row per block size from BLOCK_MIN
  localparam logic [SCORE_W-1:0] SCORE_TABLE [BLOCK_MAX-BLOCK_MIN+1][BLOCK_MAX+1] = '{
    '{17'd65536, 17'd0,     17'd0,     17'd65536, 17'd0,
      17'd0,     17'd0,     17'd0,     17'd0},
    '{17'd65536, 17'd0,     17'd58982, 17'd0,     17'd65536,
      17'd0,     17'd0,     17'd0,     17'd0},
    '{17'd65536, 17'd0,     17'd39322, 17'd39322, 17'd0,
      17'd65536, 17'd0,     17'd0,     17'd0},
    '{17'd65536, 17'd0,     17'd29491, 17'd58982, 17'd29491,
      17'd0,     17'd65536, 17'd0,     17'd0},
    '{17'd65536, 17'd0,     17'd23593, 17'd47186, 17'd47186,
      17'd23593, 17'd0,     17'd65536, 17'd0},
    '{17'd65536, 17'd0,     17'd19661, 17'd39322, 17'd58982,
      17'd39322, 17'd19661, 17'd0,     17'd65536}
  };

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               is_ones;
    logic               is_zero;
  } lane_t;

endpackage
`default_nettype wire

// ----- rtl/hierarchical_deceptive_fitness_top.sv -----
`default_nettype none
// Pipeline: a request accepted on candidate_ready is held in the lane register,
//   then in the merge, product and output registers.
// Throughput: one request per cycle while result_ready holds; stalls back up.
// Reset: rst is synchronous, active high; clears all stage valids and sets
//   level_weight to 1.0 and top_weight to 2.0 (Q4.8).
module hierarchical_deceptive_fitness_top #(
  parameter int BLOCK_SIZE = hdf_pkg::BLOCK_SIZE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // candidate channel
  input  wire logic                          candidate_valid,
  output logic                               candidate_ready,
  input  wire logic [hdf_pkg::CAND_W-1:0]    candidate_bits,
  // result channel
  output logic                               result_valid,
  input  wire logic                          result_ready,
  output logic [hdf_pkg::FIT_W-1:0]          fitness,
  output logic                               top_level_valid,
  // APB-style register port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [hdf_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [hdf_pkg::DATA_W-1:0]    pwdata,
  output logic [hdf_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  // Registers: word 0 level_weight, word 1 top_weight; the word index is
  // paddr[2], byte offset bits are ignored.
  logic [hdf_pkg::WEIGHT_W-1:0] level_weight;
  logic [hdf_pkg::WEIGHT_W-1:0] top_weight;
  logic                         reg_sel;
  logic                         wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_weight <= hdf_pkg::LEVEL_RST;
      top_weight   <= hdf_pkg::TOP_RST;
    end else if (wr_en) begin
      case (reg_sel)
        hdf_pkg::REG_LEVEL: level_weight <= pwdata[hdf_pkg::WEIGHT_W-1:0];
        hdf_pkg::REG_TOP:   top_weight   <= pwdata[hdf_pkg::WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      hdf_pkg::REG_LEVEL: prdata = hdf_pkg::DATA_W'(level_weight);
      hdf_pkg::REG_TOP:   prdata = hdf_pkg::DATA_W'(top_weight);
      default:            prdata = '0;
    endcase
  end

  // Lane stage: one lane per block, each counting ones and looking up its
  // deceptive score. Bits above BLOCK_SIZE*BLOCK_SIZE are never routed.
  logic           v1;
  logic           ready1;
  logic           lanes_ready;
  logic           lane_en;
  hdf_pkg::lane_t lanes [BLOCK_SIZE];

  assign ready1          = !v1 || lanes_ready;
  assign candidate_ready = ready1;
  assign lane_en         = candidate_valid && ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= candidate_valid;
    end
  end

  for (genvar k = 0; k < BLOCK_SIZE; k++) begin : g_lane
    hdf_lane #(
      .BLOCK_SIZE (BLOCK_SIZE)
    ) u_lane (
      .clk    (clk),
      .en     (lane_en),
      .bits   (candidate_bits[k*BLOCK_SIZE +: BLOCK_SIZE]),
      .result (lanes[k])
    );
  end

  // Merge: sums block scores, reduces blocks to the upper level, weights,
  // rounds and saturates.
  hdf_merge #(
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_merge (
    .clk             (clk),
    .rst             (rst),
    .lanes_valid     (v1),
    .lanes_ready     (lanes_ready),
    .lanes           (lanes),
    .level_weight    (level_weight),
    .top_weight      (top_weight),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .fitness         (fitness),
    .top_level_valid (top_level_valid)
  );

endmodule
`default_nettype wire

// ----- rtl/hdf_lane.sv -----
`default_nettype none
module hdf_lane #(
  parameter int BLOCK_SIZE = hdf_pkg::BLOCK_SIZE_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [BLOCK_SIZE-1:0] bits,
  output hdf_pkg::lane_t             result
);

  localparam int ROW = BLOCK_SIZE - hdf_pkg::BLOCK_MIN;

  logic [hdf_pkg::CNT_W-1:0] cnt;

  always_comb begin
    cnt = '0;
    for (int j = 0; j < BLOCK_SIZE; j++) begin
      cnt = cnt + hdf_pkg::CNT_W'(bits[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.score   <= hdf_pkg::SCORE_TABLE[ROW][cnt];
      result.is_ones <= &bits;
      result.is_zero <= ~|bits;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/hdf_merge.sv -----
`default_nettype none
module hdf_merge #(
  parameter int BLOCK_SIZE = hdf_pkg::BLOCK_SIZE_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           lanes_valid,
  output logic                                lanes_ready,
  input  wire hdf_pkg::lane_t                 lanes [BLOCK_SIZE],
  input  wire logic [hdf_pkg::WEIGHT_W-1:0]   level_weight,
  input  wire logic [hdf_pkg::WEIGHT_W-1:0]   top_weight,
  output logic                                result_valid,
  input  wire logic                           result_ready,
  output logic [hdf_pkg::FIT_W-1:0]           fitness,
  output logic                                top_level_valid
);

  localparam int ROW = BLOCK_SIZE - hdf_pkg::BLOCK_MIN;

  // merge stage
  logic                         v2;
  logic [hdf_pkg::SUM_W-1:0]    level_sum;
  logic [hdf_pkg::SCORE_W-1:0]  top_score;
  logic                         uniform2;
  // product stage
  logic                         v3;
  logic [hdf_pkg::LEVEL_W-1:0]  prod_level;
  logic [hdf_pkg::TOP_W-1:0]    prod_top;
  logic                         uniform3;

  logic ready2, ready3, ready4;

  logic [hdf_pkg::SUM_W-1:0]   sum_next;
  logic [hdf_pkg::CNT_W-1:0]   ones_next;
  logic                        uniform_next;
  logic [hdf_pkg::ACC_W-1:0]   acc;
  logic [hdf_pkg::RND_W-1:0]   rnd;

  assign ready4      = !result_valid || result_ready;
  assign ready3      = !v3 || ready4;
  assign ready2      = !v2 || ready3;
  assign lanes_ready = ready2;

  always_comb begin
    sum_next     = '0;
    ones_next    = '0;
    uniform_next = 1'b1;
    for (int k = 0; k < BLOCK_SIZE; k++) begin
      sum_next     = sum_next + hdf_pkg::SUM_W'(lanes[k].score);
      ones_next    = ones_next + hdf_pkg::CNT_W'(lanes[k].is_ones);
      uniform_next = uniform_next & (lanes[k].is_ones | lanes[k].is_zero);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= lanes_valid;
    end
    if (ready2 && lanes_valid) begin
      level_sum <= sum_next;
      top_score <= uniform_next ? hdf_pkg::SCORE_TABLE[ROW][ones_next] : '0;
      uniform2  <= uniform_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ready3) begin
      v3 <= v2;
    end
    if (ready3 && v2) begin
      prod_level <= hdf_pkg::LEVEL_W'(level_sum) * hdf_pkg::LEVEL_W'(level_weight);
      prod_top   <= hdf_pkg::TOP_W'(top_score) * hdf_pkg::TOP_W'(top_weight);
      uniform3   <= uniform2;
    end
  end

  // Q.24 sum, round to Q.16, saturate
  assign acc = hdf_pkg::ACC_W'(prod_level) + hdf_pkg::ACC_W'(prod_top) + hdf_pkg::ROUND_HALF;
  assign rnd = acc[hdf_pkg::ACC_W-1:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ready4) begin
      result_valid <= v3;
    end
    if (ready4 && v3) begin
      fitness         <= (rnd[hdf_pkg::RND_W-1:hdf_pkg::FIT_W] != '0) ? '1
                         : rnd[hdf_pkg::FIT_W-1:0];
      top_level_valid <= uniform3;
    end
  end

`ifndef NO_ASSERTIONS
  a_top_gated: assert property (@(posedge clk) disable iff (rst)
    (v2 && !uniform2) |-> (top_score == '0))
    else $error("upper score present for an undecided candidate");

  a_prod_gated: assert property (@(posedge clk) disable iff (rst)
    (v3 && !uniform3) |-> (prod_top == '0))
    else $error("upper product present for an undecided candidate");

  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (level_sum <= hdf_pkg::SUM_W'(BLOCK_SIZE * 65536)))
    else $error("block score sum out of range");

  a_delivery: assert property (@(posedge clk) disable iff (rst)
    (v3 && ready4) |=> result_valid)
    else $error("product stage lost a request");
`endif

endmodule
`default_nettype wire

// ----- tb/hierarchical_deceptive_fitness_top_tb.sv -----
module hierarchical_deceptive_fitness_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BS = hdf_pkg::BLOCK_SIZE_DEF;
  // Cycles of slack after the last result before a weight write or the end, so
  // that the pipeline has settled.
  localparam int DRAIN_CYCLES = 8;
  localparam longint unsigned FIT_CEIL = (64'd1 << hdf_pkg::FIT_W) - 1;
  localparam longint unsigned Q16_ONE = 64'd65536;

  typedef struct packed {
    logic [hdf_pkg::FIT_W-1:0] fitness;
    logic                      top_level_valid;
  } fitness_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         candidate_valid = 1'b0;
  logic                         candidate_ready;
  logic [hdf_pkg::CAND_W-1:0]   candidate_bits = '0;
  logic                         result_valid;
  logic                         result_ready = 1'b0;
  logic [hdf_pkg::FIT_W-1:0]    fitness;
  logic                         top_level_valid;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [hdf_pkg::ADDR_W-1:0]   paddr = '0;
  logic [hdf_pkg::DATA_W-1:0]   pwdata = '0;
  logic [hdf_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  // Shadow copies of the weight registers, as left by reset
  logic [hdf_pkg::WEIGHT_W-1:0] level_w = hdf_pkg::LEVEL_RST;
  logic [hdf_pkg::WEIGHT_W-1:0] top_w   = hdf_pkg::TOP_RST;

  // Predicted results, oldest first, one per accepted request
  fitness_t fitness_due[$];
  int       mismatches = 0;

  // Idling switches, redrawn per phase so that some stretches run flat out
  bit idle_send  = 1'b1;
  bit idle_drain = 1'b1;

  hierarchical_deceptive_fitness_top #(.BLOCK_SIZE(BS)) u_top (
    .clk             (clk),
    .rst             (rst),
    .candidate_valid (candidate_valid),
    .candidate_ready (candidate_ready),
    .candidate_bits  (candidate_bits),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .fitness         (fitness),
    .top_level_valid (top_level_valid),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Deceptive score of a ones count, Q.16, rounded half up
  function automatic longint unsigned deceptive_q16(longint unsigned ones);
    longint unsigned b, spread, num, den;
    b = BS;
    if (ones == 0 || ones == b) return Q16_ONE;
    if (b < 3 || ones > b) return 0;
    spread = (b >= 2 * ones) ? b - 2 * ones : 2 * ones - b;
    if (spread > b - 2) return 0;
    num = 9 * Q16_ONE * (b - 2 - spread);
    den = 10 * (b - 2);
    return (2 * num + den) / (2 * den);
  endfunction

  // Expected result for one candidate under the current weights
  function automatic fitness_t predict_fitness(logic [hdf_pkg::CAND_W-1:0] bits);
    fitness_t        res;
    longint unsigned level_sum, lifted, acc, fit, ones;
    bit              uniform;
    level_sum = 0;
    lifted = 0;
    uniform = 1'b1;
    for (int k = 0; k < BS; k++) begin
      ones = 0;
      // bits past BS*BS belong to no block
      for (int j = 0; j < BS; j++)
        if (k * BS + j < hdf_pkg::CAND_W) ones += bits[k * BS + j];
      level_sum += deceptive_q16(ones);
      if (ones == BS) lifted++;
      else if (ones != 0) uniform = 1'b0;
    end
    acc = level_sum * longint'(level_w);
    // upper level only counts when every block reduces cleanly
    if (uniform) acc += deceptive_q16(lifted) * longint'(top_w);
    fit = (acc + 128) >> 8;
    if (fit > FIT_CEIL) fit = FIT_CEIL;
    res.fitness = fit[hdf_pkg::FIT_W-1:0];
    res.top_level_valid = uniform;
    return res;
  endfunction

  // Candidate with the given number of ones at the bottom of one block
  function automatic logic [hdf_pkg::CAND_W-1:0] partial_block(int k, int ones);
    logic [hdf_pkg::CAND_W-1:0] bits;
    bits = '0;
    for (int j = 0; j < ones; j++) bits[k * BS + j] = 1'b1;
    return bits;
  endfunction

  // First n blocks all ones, the rest all zeros
  function automatic logic [hdf_pkg::CAND_W-1:0] lifted_blocks(int n);
    logic [hdf_pkg::CAND_W-1:0] bits;
    bits = '0;
    for (int k = 0; k < n; k++) bits |= partial_block(k, BS);
    return bits;
  endfunction

  // Well-formed strings four times in ten, so the upper level is reached often;
  // three in ten break one block and the rest are pure noise.
  function automatic logic [hdf_pkg::CAND_W-1:0] random_candidate();
    logic [hdf_pkg::CAND_W-1:0] bits;
    int                         kind, k;
    kind = $urandom_range(0, 9);
    bits = {$urandom, $urandom};
    if (kind < 7) begin
      for (k = 0; k < BS; k++)
        for (int j = 0; j < BS; j++) bits[k * BS + j] = bits[k * BS];
      if (kind >= 4) begin
        k = $urandom_range(0, BS - 1);
        for (int j = 0; j < BS; j++) bits[k * BS + j] = $urandom_range(0, 1);
      end
    end
    return bits;
  endfunction

  // Offer one request; valid stays up afterwards so back-to-back requests
  // never see it dropped and raised in the same step.
  task automatic send_candidate(input logic [hdf_pkg::CAND_W-1:0] bits);
    int       gap;
    fitness_t want;
    gap = idle_send ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      candidate_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    want = predict_fitness(bits);
    candidate_valid <= 1'b1;
    candidate_bits <= bits;
    do @(posedge clk); while (!candidate_ready);
    fitness_due = {fitness_due, want};
  endtask

  // Drop valid, let every outstanding result arrive, then let the pipe settle
  task automatic wait_for_results();
    candidate_valid <= 1'b0;
    while (fitness_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write while idle; junk in the upper data bits must be dropped
  task automatic write_weight(input logic idx, input logic [hdf_pkg::WEIGHT_W-1:0] value);
    wait_for_results();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= hdf_pkg::ADDR_W'({idx, 2'b00});
    pwdata <= {(hdf_pkg::DATA_W - hdf_pkg::WEIGHT_W)'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == hdf_pkg::REG_LEVEL) level_w = value;
    else top_w = value;
  endtask

  // Per-block scoring under the reset weights, including stray patterns
  task automatic test_block_scores();
    for (int u = 1; u < BS; u++) send_candidate(partial_block(u % BS, u));
    send_candidate({hdf_pkg::CAND_W/2{2'b10}});
    send_candidate({hdf_pkg::CAND_W/2{2'b01}});
    send_candidate(hdf_pkg::CAND_W'(1));
    send_candidate({1'b1, {(hdf_pkg::CAND_W-1){1'b0}}});
    send_candidate(~partial_block(BS - 1, 1));
  endtask

  // Upper level: every reduced-ones count, all-zeros and all-ones included
  task automatic test_upper_level();
    for (int n = 0; n <= BS; n++) send_candidate(lifted_blocks(n));
    send_candidate(partial_block(0, BS) | partial_block(BS - 1, BS)
                   | partial_block(BS / 2, BS));
  endtask

  // Random candidates over several weight settings, extremes first
  task automatic test_random_candidates();
    logic [hdf_pkg::WEIGHT_W-1:0] lw, tw;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin lw = '0; tw = '0; end
        1: begin lw = '1; tw = '1; end
        2: begin lw = '0; tw = '1; end
        3: begin lw = '1; tw = '0; end
        4: begin lw = hdf_pkg::LEVEL_RST; tw = hdf_pkg::TOP_RST; end
        default: begin
          lw = hdf_pkg::WEIGHT_W'($urandom);
          tw = hdf_pkg::WEIGHT_W'($urandom);
        end
      endcase
      write_weight(hdf_pkg::REG_LEVEL, lw);
      write_weight(hdf_pkg::REG_TOP, tw);
      // phase 1 runs with no idling on either side
      idle_send  = (phase == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      idle_drain = (phase == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 100; i++) begin
        // in phase 2, hold off once mid-phase until every result is in
        if (phase == 2 && i == 50) wait_for_results();
        send_candidate(random_candidate());
      end
    end
  endtask

  // Result side: random stall before each accepted result while idle_drain is set
  initial begin
    int stall;
    forever begin
      stall = idle_drain ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!(result_valid && result_ready));
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    fitness_t want;
    if (!rst && result_valid && result_ready) begin
      if (fitness_due.size() == 0) begin
        $error("result with no request outstanding: fitness %0d", fitness);
        mismatches++;
      end else begin
        want = fitness_due.pop_front();
        if (fitness !== want.fitness) begin
          $error("fitness: expected %0d, got %0d", want.fitness, fitness);
          mismatches++;
        end
        if (top_level_valid !== want.top_level_valid) begin
          $error("top_level_valid: expected %0b, got %0b",
                 want.top_level_valid, top_level_valid);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_block_scores();
    test_upper_level();
    test_random_candidates();
    wait_for_results();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/hdf_pkg.sv
rtl/hdf_lane.sv
rtl/hdf_merge.sv
rtl/hierarchical_deceptive_fitness_top.sv
tb/hierarchical_deceptive_fitness_top_tb.sv
